@@ rtl/pcws_pkg.sv @@
// ----------------------------------------------------------------------------
// pcws_pkg
// Operation codes, register indexes, constants and helpers for the square-wave
// channel with sweep, envelope and length counter.
// ----------------------------------------------------------------------------
package pcws_pkg;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_FRAME  = 2'd2;
   localparam logic [1:0] OP_PERIOD = 2'd3;

   localparam logic [2:0] REG_SWEEP    = 3'd0;
   localparam logic [2:0] REG_DUTY_LEN = 3'd1;
   localparam logic [2:0] REG_ENVELOPE = 3'd2;
   localparam logic [2:0] REG_PER_LOW  = 3'd3;
   localparam logic [2:0] REG_PER_HIGH = 3'd4;

   localparam logic [10:0] MAX_PERIOD    = 11'h7FF;
   localparam logic [6:0]  LEN_FULL      = 7'd64;
   localparam logic [3:0]  ZOMBIE_NIBBLE = 4'h8;
   localparam logic [3:0]  SWEEP_IDLE    = 4'd8;

   function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
      logic [7:0] pat;
      case (sel)
         2'd0:    pat = 8'b0000_0001;
         2'd1:    pat = 8'b0000_0011;
         2'd2:    pat = 8'b0000_1111;
         default: pat = 8'b1111_1100;
      endcase
      return pat;
   endfunction

   // shadow plus or minus shadow >> shift; bit 11 flags an overflow
   function automatic logic [11:0] sweep_sum(input logic [10:0] shadow,
                                             input logic [7:0] sweep);
      logic [10:0] delta;
      delta = shadow >> sweep[2:0];
      if (sweep[3]) begin
         return {1'b0, shadow - delta};
      end
      return {1'b0, shadow} + {1'b0, delta};
   endfunction

endpackage

@@ rtl/pulse_channel_with_sweep.sv @@
// ----------------------------------------------------------------------------
// pulse_channel_with_sweep
// Square-wave sound channel with frequency sweep, volume envelope and length
// counter.
//
// Requests arrive on the req_ channel: the operation in req_tuser, the
// register index and write byte in req_tdata. Each request is a register
// write, a register read, a frame-sequencer tick or a period tick.
// Every request yields exactly one response on the rsp_ channel carrying
// read data, channel and DAC status, the digital level and the period.
// The full state update is one combinational pass from the state registers
// into the response register: rsp_tvalid rises in the cycle after acceptance,
// and one request is taken every cycle unless a held response stalls it.
// req_tready drops only while a response is held because rsp_tready is low;
// the request arriving in the cycle the response is taken is accepted.
// Synchronous reset clears all registers but rsp_tdata; frame_ff restarts so
// that the first frame tick is step 0. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module pulse_channel_with_sweep
   import pcws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // reg_index[2:0], write_data[10:3]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // read_data[7:0], channel_active[8], dac_on[9],
                                    // sample_level[13:10], current_period[24:14]
);

   logic [7:0]  sweep_ff, sweep_in;
   logic [7:0]  duty_len_ff, duty_len_in;
   logic [7:0]  env_ff, env_in;
   logic [7:0]  per_low_ff, per_low_in;
   logic [7:0]  per_high_ff, per_high_in;
   logic        on_ff, on_in;
   logic [6:0]  len_ff, len_in;
   logic [3:0]  vol_ff, vol_in;
   logic [2:0]  env_timer_ff, env_timer_in;
   logic [3:0]  sweep_timer_ff, sweep_timer_in;
   logic        sweep_act_ff, sweep_act_in;
   logic [10:0] shadow_ff, shadow_in;
   logic        sub_ff, sub_in;
   logic [10:0] count_ff, count_in;
   logic [2:0]  duty_step_ff, duty_step_in;
   logic [2:0]  frame_ff, frame_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic        accept;
   logic [1:0]  op;
   logic [2:0]  idx;
   logic [7:0]  wdata;

   assign op     = req_tuser;
   assign idx    = req_tdata[2:0];
   assign wdata  = req_tdata[10:3];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      logic [11:0] nxt1;
      logic [11:0] nxt2;
      logic [2:0]  pace;
      logic        fire;
      logic        was_en;
      logic [7:0]  rd;
      logic [3:0]  level;
      logic [7:0]  pat;

      sweep_in       = sweep_ff;
      duty_len_in    = duty_len_ff;
      env_in         = env_ff;
      per_low_in     = per_low_ff;
      per_high_in    = per_high_ff;
      on_in          = on_ff;
      len_in         = len_ff;
      vol_in         = vol_ff;
      env_timer_in   = env_timer_ff;
      sweep_timer_in = sweep_timer_ff;
      sweep_act_in   = sweep_act_ff;
      shadow_in      = shadow_ff;
      sub_in         = sub_ff;
      count_in       = count_ff;
      duty_step_in   = duty_step_ff;
      frame_in       = frame_ff;
      nxt1           = 12'd0;
      nxt2           = 12'd0;
      pace           = sweep_ff[6:4];
      fire           = 1'b0;
      was_en         = per_high_ff[6];
      rd             = 8'h00;

      case (op)
         OP_WRITE: begin
            case (idx)
               REG_SWEEP: begin
                  sweep_in = wdata | 8'h80;
                  if (sub_ff && !sweep_in[3]) on_in = 1'b0;
               end
               REG_DUTY_LEN: begin
                  duty_len_in = wdata;
                  len_in      = LEN_FULL - {1'b0, wdata[5:0]};
               end
               REG_ENVELOPE: begin
                  env_in = wdata;
                  if (wdata[7:3] == 5'd0) begin
                     on_in = 1'b0;
                  end else if (on_ff && wdata[3:0] == ZOMBIE_NIBBLE) begin
                     vol_in = vol_ff + 4'd1;
                  end
               end
               REG_PER_LOW: begin
                  per_low_in = wdata;
               end
               REG_PER_HIGH: begin
                  per_high_in = wdata | 8'h38;
                  if (!was_en && per_high_in[6] && !frame_ff[0] && len_in != 7'd0) begin
                     len_in = len_in - 7'd1;
                     if (len_in == 7'd0) on_in = 1'b0;
                  end
                  if (per_high_in[7]) begin
                     count_in = {per_high_in[2:0], per_low_ff};
                     if (len_in == 7'd0) begin
                        len_in = LEN_FULL;
                        if (!frame_ff[0] && per_high_in[6]) len_in = LEN_FULL - 7'd1;
                     end
                     env_timer_in = env_ff[2:0];
                     vol_in       = env_ff[7:4];
                     if (env_ff[7:3] != 5'd0) on_in = 1'b1;
                     sub_in         = 1'b0;
                     shadow_in      = {per_high_in[2:0], per_low_ff};
                     sweep_timer_in = (pace != 3'd0) ? {1'b0, pace} : SWEEP_IDLE;
                     sweep_act_in   = (pace != 3'd0) || (sweep_ff[2:0] != 3'd0);
                     if (sweep_ff[2:0] != 3'd0) begin
                        nxt1 = sweep_sum(shadow_in, sweep_ff);
                        if (sweep_ff[3]) sub_in = 1'b1;
                        if (nxt1[11]) on_in = 1'b0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         OP_READ: begin
            case (idx)
               REG_SWEEP:    rd = sweep_ff | 8'h80;
               REG_DUTY_LEN: rd = duty_len_ff | 8'h3F;
               REG_ENVELOPE: rd = env_ff;
               REG_PER_HIGH: rd = per_high_ff | 8'hBF;
               default:      rd = 8'hFF;
            endcase
         end
         OP_FRAME: begin
            frame_in = frame_ff + 3'd1;
            if (frame_in[1:0] == 2'd2) begin
               fire = 1'b1;
               if (sweep_timer_ff != 4'd0) begin
                  sweep_timer_in = sweep_timer_ff - 4'd1;
                  fire = (sweep_timer_in == 4'd0);
               end
               if (fire) begin
                  sweep_timer_in = (pace != 3'd0) ? {1'b0, pace} : SWEEP_IDLE;
                  if (sweep_act_ff && pace != 3'd0) begin
                     nxt1 = sweep_sum(shadow_ff, sweep_ff);
                     if (sweep_ff[3]) sub_in = 1'b1;
                     if (nxt1[11]) on_in = 1'b0;
                     if (!nxt1[11] && sweep_ff[2:0] != 3'd0) begin
                        per_low_in  = nxt1[7:0];
                        per_high_in = {per_high_ff[7:3], nxt1[10:8]};
                        shadow_in   = nxt1[10:0];
                        nxt2 = sweep_sum(nxt1[10:0], sweep_ff);
                        if (nxt2[11]) on_in = 1'b0;
                     end
                  end
               end
            end
            if (frame_in == 3'd7 && env_ff[2:0] != 3'd0) begin
               fire = 1'b1;
               if (env_timer_ff != 3'd0) begin
                  env_timer_in = env_timer_ff - 3'd1;
                  fire = (env_timer_in == 3'd0);
               end
               if (fire) begin
                  env_timer_in = env_ff[2:0];
                  if (env_ff[3]) begin
                     if (vol_ff != 4'd15) vol_in = vol_ff + 4'd1;
                  end else begin
                     if (vol_ff != 4'd0) vol_in = vol_ff - 4'd1;
                  end
               end
            end
            if (!frame_in[0] && per_high_in[6] && len_in != 7'd0) begin
               len_in = len_in - 7'd1;
               if (len_in == 7'd0) on_in = 1'b0;
            end
         end
         OP_PERIOD: begin
            if (on_ff) begin
               if (count_ff == MAX_PERIOD) begin
                  count_in     = {per_high_ff[2:0], per_low_ff};
                  duty_step_in = duty_step_ff + 3'd1;
               end else begin
                  count_in = count_ff + 11'd1;
               end
            end
         end
         default: begin
         end
      endcase

      pat   = duty_pattern(duty_len_in[7:6]);
      level = (on_in && pat[duty_step_in]) ? vol_in : 4'd0;
      rsp_data_in = {7'd0, per_high_in[2:0], per_low_in, level,
                     (env_in[7:3] != 5'd0), on_in, rd};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff       <= 8'd0;
         duty_len_ff    <= 8'd0;
         env_ff         <= 8'd0;
         per_low_ff     <= 8'd0;
         per_high_ff    <= 8'd0;
         on_ff          <= 1'b0;
         len_ff         <= 7'd0;
         vol_ff         <= 4'd0;
         env_timer_ff   <= 3'd0;
         sweep_timer_ff <= 4'd0;
         sweep_act_ff   <= 1'b0;
         shadow_ff      <= 11'd0;
         sub_ff         <= 1'b0;
         count_ff       <= 11'd0;
         duty_step_ff   <= 3'd0;
         frame_ff       <= 3'd7;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            sweep_ff       <= sweep_in;
            duty_len_ff    <= duty_len_in;
            env_ff         <= env_in;
            per_low_ff     <= per_low_in;
            per_high_ff    <= per_high_in;
            on_ff          <= on_in;
            len_ff         <= len_in;
            vol_ff         <= vol_in;
            env_timer_ff   <= env_timer_in;
            sweep_timer_ff <= sweep_timer_in;
            sweep_act_ff   <= sweep_act_in;
            shadow_ff      <= shadow_in;
            sub_ff         <= sub_in;
            count_ff       <= count_in;
            duty_step_ff   <= duty_step_in;
            frame_ff       <= frame_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_on_needs_dac: assert property (@(posedge clock) disable iff (reset)
      on_ff |-> (env_ff[7:3] != 5'd0))
      else $error("channel on with DAC disabled");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_FULL)
      else $error("length counter above full");

   a_level_needs_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[13:10] != 4'd0 |-> rsp_data_ff[8])
      else $error("nonzero level while channel off");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while response held");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(frame_ff) && $stable(count_ff) && $stable(on_ff))
      else $error("state changed without a request");

endmodule
